// ===== design/twdp_pkg.sv =====
// ----------------------------------------------------------------------------
// twdp_pkg
// Shared types, constants and the base-3 weight decoder for the ternary
// weight dot-product block.
// ----------------------------------------------------------------------------
package twdp_pkg;

  // Default widths for activations and the accumulator.
  localparam int unsigned ACT_WIDTH_DEF = 16;
  localparam int unsigned ACC_WIDTH_DEF = 32;

  // Field widths fixed by the interface.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;

  // Five base-3 digits fit in one byte.
  localparam int unsigned NUM_TRITS = 5;

  // Digit codes: the weight is the digit minus one.
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  // Reciprocal of three for values below 256: q = (r * 171) >> 9.
  localparam logic [BYTE_W-1:0] RECIP3      = 8'd171;
  localparam int unsigned       RECIP3_SHIFT = 9;
  localparam logic [BYTE_W-1:0] THREE       = 8'd3;

  typedef logic [NUM_TRITS-1:0][1:0] trits_t;

  // Control that moves with one request into the accumulator.
  typedef struct packed {
    logic go;
    logic last;
  } acc_ctrl_t;

  // Splits a byte into five base-3 digits, least significant first.
  // Each step divides by three through a reciprocal multiply.
  function automatic trits_t decode_trits(input logic [BYTE_W-1:0] byte_v);
    logic [BYTE_W-1:0]   rem_v;
    logic [BYTE_W-1:0]   quo_v;
    logic [2*BYTE_W-1:0] prod_v;
    trits_t              trits_v;
    rem_v   = byte_v;
    trits_v = '0;
    for (int i = 0; i < NUM_TRITS; i++) begin
      prod_v     = (2*BYTE_W)'(rem_v) * (2*BYTE_W)'(RECIP3);
      quo_v      = BYTE_W'(prod_v >> RECIP3_SHIFT);
      trits_v[i] = 2'(rem_v - BYTE_W'(quo_v * THREE));
      rem_v      = quo_v;
    end
    return trits_v;
  endfunction

endpackage

// ===== design/twdp_group_sum.sv =====
// ----------------------------------------------------------------------------
// twdp_group_sum
// Decodes the packed ternary weights and forms the exact signed sum of the
// weighted activations of one request that its digit count selects.
// ----------------------------------------------------------------------------
module twdp_group_sum #(
  parameter int unsigned ACT_WIDTH = twdp_pkg::ACT_WIDTH_DEF
) (
  input  logic [twdp_pkg::BYTE_W-1:0]  weight_byte_i,
  input  logic [ACT_WIDTH-1:0]         act_i [twdp_pkg::NUM_TRITS],
  input  logic [twdp_pkg::COUNT_W-1:0] valid_trits_i,
  output logic signed [ACT_WIDTH+2:0]  group_o
);

  localparam int unsigned GrpW = ACT_WIDTH + 3;

  twdp_pkg::trits_t             trits;
  logic [twdp_pkg::COUNT_W-1:0] count_lim;

  assign trits = twdp_pkg::decode_trits(weight_byte_i);

  // Counts above five use all five digits.
  assign count_lim = (valid_trits_i > twdp_pkg::COUNT_W'(twdp_pkg::NUM_TRITS))
                   ? twdp_pkg::COUNT_W'(twdp_pkg::NUM_TRITS) : valid_trits_i;

  // Add or subtract each used activation according to its digit.
  always_comb begin
    logic signed [GrpW-1:0] act_ext;
    logic signed [GrpW-1:0] sum_v;
    sum_v = '0;
    for (int i = 0; i < twdp_pkg::NUM_TRITS; i++) begin
      act_ext = GrpW'($signed(act_i[i]));
      if (twdp_pkg::COUNT_W'(i) < count_lim) begin
        case (trits[i])
          twdp_pkg::TRIT_POS: sum_v = sum_v + act_ext;
          twdp_pkg::TRIT_NEG: sum_v = sum_v - act_ext;
          default:            sum_v = sum_v;
        endcase
      end
    end
    group_o = sum_v;
  end

endmodule

// ===== design/twdp_accum.sv =====
// ----------------------------------------------------------------------------
// twdp_accum
// Saturating running sum with a sticky clip flag, and the result register
// that presents the finished dot product on the output channel.
// ----------------------------------------------------------------------------
module twdp_accum #(
  parameter int unsigned ACT_WIDTH = twdp_pkg::ACT_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH = twdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  twdp_pkg::acc_ctrl_t         ctrl_i,
  input  logic signed [ACT_WIDTH+2:0] group_i,
  input  logic                        out_stall_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  output logic [ACC_WIDTH-1:0]        dot_sum_o,
  output logic                        saturated_o
);

  localparam int unsigned SumW = ((ACC_WIDTH > ACT_WIDTH + 3) ? ACC_WIDTH : ACT_WIDTH + 3) + 1;
  localparam logic signed [SumW-1:0] AccHi =
    SumW'($signed({1'b0, {(ACC_WIDTH-1){1'b1}}}));
  localparam logic signed [SumW-1:0] AccLo =
    SumW'($signed({1'b1, {(ACC_WIDTH-1){1'b0}}}));

  logic signed [ACC_WIDTH-1:0] running_sum_q, running_sum_d;
  logic                        clip_seen_q, clip_seen_d;
  logic                        out_valid_q, out_valid_d;
  logic [ACC_WIDTH-1:0]        out_sum_q, out_sum_d;
  logic                        out_sat_q, out_sat_d;

  logic signed [SumW-1:0]      sum_wide;
  logic signed [ACC_WIDTH-1:0] sum_clamped;
  logic                        clipped;
  logic                        load_out;

  // Exact sum, then clamp to the accumulator range.
  assign sum_wide = SumW'(running_sum_q) + SumW'(group_i);

  always_comb begin
    if (sum_wide > AccHi) begin
      sum_clamped = ACC_WIDTH'(AccHi);
      clipped     = 1'b1;
    end else if (sum_wide < AccLo) begin
      sum_clamped = ACC_WIDTH'(AccLo);
      clipped     = 1'b1;
    end else begin
      sum_clamped = ACC_WIDTH'(sum_wide);
      clipped     = 1'b0;
    end
  end

  // The running state clears after the final group of a run.
  always_comb begin
    running_sum_d = running_sum_q;
    clip_seen_d   = clip_seen_q;
    if (ctrl_i.go) begin
      if (ctrl_i.last) begin
        running_sum_d = '0;
        clip_seen_d   = 1'b0;
      end else begin
        running_sum_d = sum_clamped;
        clip_seen_d   = clip_seen_q | clipped;
      end
    end
  end

  // The result register is free when empty or being drained.
  assign out_free_o = !out_valid_q || !out_stall_i;
  assign load_out   = ctrl_i.go && ctrl_i.last;

  always_comb begin
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_sat_d   = out_sat_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_sum_d   = sum_clamped;
      out_sat_d   = clip_seen_q | clipped;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      clip_seen_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      clip_seen_q   <= clip_seen_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_sum_q <= out_sum_d;
    out_sat_q <= out_sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = out_sum_q;
  assign saturated_o = out_sat_q;

endmodule

// ===== design/ternary_weight_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// ternary_weight_dot_product_top
// Ternary-weight dot-product accumulator with base-3 packed weights.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle: a packed byte of five base-3
// weights (-1, 0, +1) with five signed activations, a count of used digits
// and a last flag. Each request is captured in an input register, its group
// sum is formed and added to a saturating running sum, and a last request
// loads that sum into the result register, which presents the dot product
// on the output. The running sum and clip flag then clear for the next run.
// The input stalls only when a last request waits in the input register
// while the result register still holds an earlier result that the output
// side has not taken.
module ternary_weight_dot_product_top #(
  parameter int unsigned ACT_WIDTH = twdp_pkg::ACT_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH = twdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [twdp_pkg::BYTE_W-1:0]  weight_byte_i,
  input  logic [ACT_WIDTH-1:0]         act_0_i,
  input  logic [ACT_WIDTH-1:0]         act_1_i,
  input  logic [ACT_WIDTH-1:0]         act_2_i,
  input  logic [ACT_WIDTH-1:0]         act_3_i,
  input  logic [ACT_WIDTH-1:0]         act_4_i,
  input  logic [twdp_pkg::COUNT_W-1:0] valid_trits_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ACC_WIDTH-1:0]         dot_sum_o,
  output logic                         saturated_o
);

  logic                         s1_valid_q, s1_valid_d;
  logic [twdp_pkg::BYTE_W-1:0]  s1_byte_q;
  logic [ACT_WIDTH-1:0]         s1_act_q [twdp_pkg::NUM_TRITS];
  logic [twdp_pkg::COUNT_W-1:0] s1_count_q;
  logic                         s1_last_q;

  logic                         in_accept;
  logic                         out_free;
  logic signed [ACT_WIDTH+2:0]  group_sum;
  twdp_pkg::acc_ctrl_t          acc_ctrl;

  // A held request moves on unless it is final and the result slot is busy.
  assign acc_ctrl.go   = s1_valid_q && (!s1_last_q || out_free);
  assign acc_ctrl.last = s1_last_q;

  assign in_stall_o = s1_valid_q && !acc_ctrl.go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (acc_ctrl.go) begin
      s1_valid_d = 1'b0;
    end
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q   <= weight_byte_i;
      s1_act_q[0] <= act_0_i;
      s1_act_q[1] <= act_1_i;
      s1_act_q[2] <= act_2_i;
      s1_act_q[3] <= act_3_i;
      s1_act_q[4] <= act_4_i;
      s1_count_q  <= valid_trits_i;
      s1_last_q   <= last_i;
    end
  end

  // Weighted group sum of the held request.
  twdp_group_sum #(
    .ACT_WIDTH(ACT_WIDTH)
  ) u_group_sum (
    .weight_byte_i(s1_byte_q),
    .act_i        (s1_act_q),
    .valid_trits_i(s1_count_q),
    .group_o      (group_sum)
  );

  // Saturating accumulator and result register.
  twdp_accum #(
    .ACT_WIDTH(ACT_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .group_i    (group_sum),
    .out_stall_i(out_stall_i),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .dot_sum_o  (dot_sum_o),
    .saturated_o(saturated_o)
  );

endmodule

// ===== design/twdp_checker.sv =====
// ----------------------------------------------------------------------------
// twdp_checker
// Port-level checks on the ternary weight dot-product block, bound to the
// top level.
// ----------------------------------------------------------------------------
module twdp_checker #(
  parameter int unsigned ACC_WIDTH = twdp_pkg::ACC_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 last_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ACC_WIDTH-1:0] dot_sum_o,
  input logic                 saturated_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dot_sum_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // The input side stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A taken final request reaches the output when the slot is then free.
  a_last_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) ##1 !out_valid_o |=> out_valid_o)
    else $error("result missing after final request");

  // An empty result register never stalls the input.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the result register is empty");

endmodule

bind ternary_weight_dot_product_top twdp_checker #(
  .ACC_WIDTH(ACC_WIDTH)
) u_twdp_checker (.*);

// ===== bench/tb_ternary_weight_dot_product_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ternary_weight_dot_product_top
// Self-checking bench for the ternary-weight dot-product accumulator. Requests
// go through a bursty sender, and a receiver stalls in changing patterns. Each
// accepted request updates a local model of the running sum and clip flag.
// A last request queues the expected dot product, and every result taken
// from the block is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module tb_ternary_weight_dot_product_top;

  localparam int unsigned ACT_W = twdp_pkg::ACT_WIDTH_DEF;
  localparam int unsigned ACC_W = twdp_pkg::ACC_WIDTH_DEF;

  localparam logic signed [ACT_W-1:0] ACT_MAX = 16'sh7FFF;
  localparam logic signed [ACT_W-1:0] ACT_MIN = 16'sh8000;

  // Bytes whose five digits are all the same.
  localparam logic [twdp_pkg::BYTE_W-1:0] ALL_NEG  = 8'd0;
  localparam logic [twdp_pkg::BYTE_W-1:0] ALL_ZERO = 8'd121;
  localparam logic [twdp_pkg::BYTE_W-1:0] ALL_POS  = 8'd242;

  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 8;

  typedef struct {
    logic [twdp_pkg::BYTE_W-1:0]  weight_byte;
    logic signed [ACT_W-1:0]      act [twdp_pkg::NUM_TRITS];
    logic [twdp_pkg::COUNT_W-1:0] valid_trits;
    logic                         last;
  } request_t;

  typedef struct {
    logic signed [ACC_W-1:0] dot_sum;
    logic                    saturated;
  } dot_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [twdp_pkg::BYTE_W-1:0]  weight_byte_i = '0;
  logic [ACT_W-1:0]             act_0_i       = '0;
  logic [ACT_W-1:0]             act_1_i       = '0;
  logic [ACT_W-1:0]             act_2_i       = '0;
  logic [ACT_W-1:0]             act_3_i       = '0;
  logic [ACT_W-1:0]             act_4_i       = '0;
  logic [twdp_pkg::COUNT_W-1:0] valid_trits_i = '0;
  logic                         last_i        = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [ACC_W-1:0]             dot_sum_o;
  logic                         saturated_o;

  // Model state of the block.
  longint      dot_acc   = 0;
  logic        clip_flag = 1'b0;
  dot_result_t expected_dots [$];

  int unsigned error_count   = 0;
  int unsigned burst_left    = 0;

  ternary_weight_dot_product_top dut (.*);

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Applies one request to the model; a last request queues the dot product.
  function automatic void accumulate_request(input request_t req);
    int unsigned rest;
    int unsigned used;
    logic [1:0]  digit;
    longint      grp;
    longint      hi;
    longint      lo;
    dot_result_t res;
    rest = req.weight_byte;
    used = (req.valid_trits > twdp_pkg::NUM_TRITS) ? twdp_pkg::NUM_TRITS : req.valid_trits;
    grp  = 0;
    hi   = (longint'(1) << (ACC_W - 1)) - 1;
    lo   = -hi - 1;
    for (int unsigned i = 0; i < used; i++) begin
      digit = 2'(rest % 3);
      rest  = rest / 3;
      if (digit == twdp_pkg::TRIT_POS) begin
        grp += longint'(req.act[i]);
      end else if (digit == twdp_pkg::TRIT_NEG) begin
        grp -= longint'(req.act[i]);
      end
    end
    // Clamp at the accumulator rails and remember that it happened.
    if (grp > 0 && dot_acc > hi - grp) begin
      dot_acc   = hi;
      clip_flag = 1'b1;
    end else if (grp < 0 && dot_acc < lo - grp) begin
      dot_acc   = lo;
      clip_flag = 1'b1;
    end else begin
      dot_acc += grp;
    end
    if (req.last) begin
      res.dot_sum   = ACC_W'(dot_acc);
      res.saturated = clip_flag;
      expected_dots.push_back(res);
      dot_acc   = 0;
      clip_flag = 1'b0;
    end
  endfunction

  function automatic request_t build_request(
    input logic [twdp_pkg::BYTE_W-1:0] weight_byte,
    input logic signed [ACT_W-1:0] a0, a1, a2, a3, a4,
    input logic [twdp_pkg::COUNT_W-1:0] valid_trits,
    input logic last
  );
    request_t req;
    req.weight_byte = weight_byte;
    req.act[0]      = a0;
    req.act[1]      = a1;
    req.act[2]      = a2;
    req.act[3]      = a3;
    req.act[4]      = a4;
    req.valid_trits = valid_trits;
    req.last        = last;
    return req;
  endfunction

  // Full-range values most of the time, rails and small values otherwise.
  function automatic logic signed [ACT_W-1:0] random_act();
    logic signed [ACT_W-1:0] val;
    case ($urandom_range(0, 7))
      0: val = ACT_MAX;
      1: val = ACT_MIN;
      2: val = ACT_W'($signed($urandom_range(0, 16)) - 8);
      default: val = ACT_W'($urandom);
    endcase
    return val;
  endfunction

  // Drives one request, waits until it is taken, then maybe idles.
  task automatic send_request(input request_t req);
    int unsigned gap;
    @(negedge clk_i);
    weight_byte_i <= req.weight_byte;
    act_0_i       <= req.act[0];
    act_1_i       <= req.act[1];
    act_2_i       <= req.act[2];
    act_3_i       <= req.act[3];
    act_4_i       <= req.act[4];
    valid_trits_i <= req.valid_trits;
    last_i        <= req.last;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accumulate_request(req);
    // Bursts of random length, most of them followed by a short gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Lowers valid and waits for every queued result, then for the pipeline.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // All-negative, all-positive and all-zero digits at the activation rails,
  // and bytes above 242 where the top digit wraps.
  task automatic test_digit_patterns();
    send_request(build_request(ALL_POS, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX,
                               3'd5, 1'b1));
    send_request(build_request(ALL_POS, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN,
                               3'd5, 1'b1));
    send_request(build_request(ALL_NEG, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN,
                               3'd5, 1'b1));
    send_request(build_request(ALL_NEG, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX,
                               3'd5, 1'b1));
    send_request(build_request(ALL_ZERO, ACT_MAX, ACT_MIN, ACT_MAX, ACT_MIN, ACT_MAX,
                               3'd5, 1'b1));
    send_request(build_request(8'd243, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd5, 1'b1));
    send_request(build_request(8'd255, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd5, 1'b1));
    send_request(build_request(8'd248, -16'sd3, 16'sd5, -16'sd7, 16'sd11, 16'sd13,
                               3'd5, 1'b1));
    wait_for_results();
  endtask

  // Zero, partial and oversized digit counts; the unused digits must not count.
  task automatic test_valid_counts();
    send_request(build_request(ALL_POS, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX,
                               3'd0, 1'b1));
    send_request(build_request(8'd250, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
                               16'sd500, 3'd6, 1'b1));
    send_request(build_request(8'd255, 16'sd100, -16'sd200, 16'sd300, -16'sd400,
                               16'sd500, 3'd7, 1'b1));
    send_request(build_request(8'd77, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd1, 1'b1));
    send_request(build_request(8'd200, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd2, 1'b1));
    send_request(build_request(8'd13, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd3, 1'b1));
    send_request(build_request(8'd180, 16'sd1, 16'sd2, 16'sd4, 16'sd8, 16'sd16,
                               3'd4, 1'b1));
    wait_for_results();
  endtask

  // A run of several requests where only the final one produces a result.
  task automatic test_multi_item_run();
    send_request(build_request(8'd100, ACT_MAX, 16'sd7, ACT_MIN, -16'sd1, 16'sd9,
                               3'd5, 1'b0));
    send_request(build_request(8'd31, 16'sd256, -16'sd256, 16'sd512, 16'sd0, 16'sd1,
                               3'd0, 1'b0));
    send_request(build_request(8'd222, -16'sd1000, 16'sd2000, ACT_MAX, ACT_MIN,
                               16'sd42, 3'd4, 1'b0));
    send_request(build_request(8'd5, ACT_MAX, ACT_MAX, ACT_MAX, 16'sd0, 16'sd0,
                               3'd3, 1'b1));
    wait_for_results();
  endtask

  // Random runs: many short runs of one to three requests to crowd the result
  // side, the rest longer runs with random bytes, activations and counts.
  task automatic test_random_runs();
    request_t    req;
    int unsigned run_len;
    int unsigned sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int unsigned k = 0; k < run_len; k++) begin
        req.weight_byte = twdp_pkg::BYTE_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < twdp_pkg::NUM_TRITS; i++) begin
          req.act[i] = random_act();
        end
        req.valid_trits = ($urandom_range(0, 9) < 7)
                        ? twdp_pkg::COUNT_W'(twdp_pkg::NUM_TRITS)
                        : twdp_pkg::COUNT_W'($urandom_range(0, 7));
        req.last = (k == run_len - 1);
        send_request(req);
      end
      sent += run_len;
    end
    wait_for_results();
  endtask

  // Receiver stall pattern: free, light, heavy or periodic, in random windows.
  initial begin : receiver_pattern
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(16, 200);
      period = $urandom_range(2, 12);
      for (int unsigned c = 0; c < span; c++) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 8);
          default: out_stall_i <= ((c % period) != 0);
        endcase
      end
    end
  end

  // Compares each result taken with the oldest expected dot product.
  always @(posedge clk_i) begin
    dot_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dots.size() == 0) begin
        $error("unexpected result: dot_sum %0d saturated %0b",
               $signed(dot_sum_o), saturated_o);
        error_count++;
      end else begin
        exp_res = expected_dots.pop_front();
        if (dot_sum_o !== exp_res.dot_sum) begin
          $error("dot_sum mismatch: expected %0d, got %0d",
                 exp_res.dot_sum, $signed(dot_sum_o));
          error_count++;
        end
        if (saturated_o !== exp_res.saturated) begin
          $error("saturated mismatch: expected %0b, got %0b",
                 exp_res.saturated, saturated_o);
          error_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_digit_patterns();
    test_valid_counts();
    test_multi_item_run();
    test_random_runs();

    if (expected_dots.size() != 0) begin
      $error("%0d expected results never arrived", expected_dots.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/twdp_pkg.sv
design/twdp_group_sum.sv
design/twdp_accum.sv
design/ternary_weight_dot_product_top.sv
design/twdp_checker.sv
bench/tb_ternary_weight_dot_product_top.sv
